// ----- sv/cdrc_pkg.sv -----
// shared types and constants of the cartridge dma register controller
`default_nettype none

package cdrc_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    localparam logic [3:0] RG_DRAM         = 4'd0;
    localparam logic [3:0] RG_CART         = 4'd1;
    localparam logic [3:0] RG_RDLEN        = 4'd2;
    localparam logic [3:0] RG_WRLEN        = 4'd3;
    localparam logic [3:0] RG_STATUS       = 4'd4;
    localparam logic [3:0] RG_TIMING_FIRST = 4'd5;
    localparam logic [3:0] RG_TIMING_LAST  = 4'd12;
    localparam int         TIMING_COUNT    = 8;

    localparam logic [2:0] KIND_NONE        = 3'd0;
    localparam logic [2:0] KIND_RDRAM_SRAM  = 3'd1;
    localparam logic [2:0] KIND_RDRAM_FLASH = 3'd2;
    localparam logic [2:0] KIND_SRAM_RDRAM  = 3'd3;
    localparam logic [2:0] KIND_FLASH_RDRAM = 3'd4;
    localparam logic [2:0] KIND_ROM_RDRAM   = 3'd5;
    localparam logic [2:0] KIND_IGNORED     = 3'd6;
    localparam logic [2:0] KIND_ERROR       = 3'd7;

    localparam logic [1:0] CFG_ROM_BYTES     = 2'd0;
    localparam logic [1:0] CFG_SAVE_IS_FLASH = 2'd1;

    localparam logic [31:0] SAVE_BASE    = 32'h0800_0000;
    localparam logic [31:0] SAVE_END     = 32'h0801_0000;
    localparam logic [31:0] ROM_BASE     = 32'h1000_0000;
    localparam logic [31:0] BOOT_BASE    = 32'h1FC0_0000;
    localparam logic [31:0] IGNORE_BASE  = 32'h0600_0000;
    localparam logic [32:0] RDRAM_LIMIT  = 33'd8388607;
    localparam logic [21:0] FIXED_DELAY  = 22'h1000;
    localparam logic [26:0] ROM_BYTES_RESET = 27'd16777216;

    typedef struct packed {
        logic        en;
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] mask;
        logic [1:0]  status_set;
        logic        status_clr;
    } cdrc_upd_t;

    typedef struct packed {
        logic [31:0] rd_word;
        logic [31:0] dram;
        logic [31:0] cart;
        logic [31:0] wrlen;
    } cdrc_view_t;

endpackage

`default_nettype wire

// ----- sv/cart_dma_register_controller.sv -----
// cartridge dma register controller: access decode, transfer descriptor and clip
// pipeline: an accepted access beat goes through the input and result registers
// throughput: one access per cycle while not stalled; register state is updated
//   as an access enters the result register, so the next sees it without a gap
// reset: register file cleared, rom size 16 MiB, save memory sram, pipe empty
`default_nettype none

module cart_dma_register_controller
    import cdrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  reg_index,
    input  wire logic [31:0] write_value,
    input  wire logic [31:0] write_mask,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [31:0]      read_data,
    output logic [2:0]       dma_kind,
    output logic [24:0]      dma_length,
    output logic [25:0]      rom_offset,
    output logic [22:0]      dram_address,
    output logic [21:0]      interrupt_delay,
    output logic             interrupt_clear
);

    // configuration
    logic [26:0] rom_bytes_reg;
    logic        flash_reg;

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [3:0]  s1_idx_reg;
    logic [31:0] s1_value_reg;
    logic [31:0] s1_mask_reg;

    // result
    logic        rsp_valid_reg;
    logic [31:0] rdata_reg;
    logic [2:0]  kind_reg;
    logic [24:0] length_reg;
    logic [25:0] offset_reg;
    logic [22:0] dram_addr_reg;
    logic [21:0] delay_reg;
    logic        clr_reg;

    logic en_out;
    logic en_s1;

    cdrc_upd_t  upd;
    cdrc_view_t view;

    // decode
    logic [31:0] s1_rdata;
    logic [2:0]  s1_kind;
    logic        s1_rom;
    logic        s1_start;
    logic        s1_clr;
    logic        in_save;
    logic [25:0] off;
    logic [24:0] len0;
    logic [26:0] rom_minus;
    logic        off_gt;
    logic [24:0] len1;

    // rom and rdram clip
    logic        dram_gt;
    logic [32:0] lim_minus;
    logic [24:0] len2;
    logic        rom_err;
    logic [2:0]  kind_next;
    logic [24:0] length_next;
    logic [21:0] delay_next;

    assign en_out    = !rsp_valid_reg || !rsp_stall;
    assign en_s1     = !s1_valid_reg || en_out;
    assign req_stall = !en_s1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bytes_reg <= ROM_BYTES_RESET;
            flash_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROM_BYTES:     rom_bytes_reg <= cfg_data[26:0];
                CFG_SAVE_IS_FLASH: flash_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    cdrc_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .view  (view)
    );

    assign in_save   = (view.cart >= SAVE_BASE) && (view.cart < SAVE_END);
    assign off       = view.cart[25:0];
    assign len0      = {1'b0, view.wrlen[23:0]} + 25'd1;
    assign off_gt    = {1'b0, off} > rom_bytes_reg;
    assign rom_minus = rom_bytes_reg - {1'b0, off};

    always_comb
    begin
        if (off_gt)
        begin
            len1 = 25'd0;
        end
        else if ({2'b00, len0} > rom_minus)
        begin
            len1 = rom_minus[24:0];
        end
        else
        begin
            len1 = len0;
        end
    end

    always_comb
    begin
        upd.en         = s1_valid_reg && en_out;
        upd.op         = s1_op_reg;
        upd.idx        = s1_idx_reg;
        upd.value      = s1_value_reg;
        upd.mask       = s1_mask_reg;
        s1_rdata       = 32'd0;
        s1_kind        = KIND_NONE;
        s1_rom         = 1'b0;
        s1_start       = 1'b0;
        s1_clr         = 1'b0;
        upd.status_set = 2'b00;
        upd.status_clr = 1'b0;
        unique case (s1_op_reg)
            OP_READ:
            begin
                s1_rdata = view.rd_word;
            end
            OP_WRITE:
            begin
                unique case (s1_idx_reg)
                    RG_RDLEN:
                    begin
                        s1_start       = 1'b1;
                        upd.status_set = 2'b01;
                        if (in_save)
                        begin
                            s1_kind = flash_reg ? KIND_RDRAM_FLASH : KIND_RDRAM_SRAM;
                        end
                        else
                        begin
                            s1_kind = KIND_ERROR;
                        end
                    end
                    RG_WRLEN:
                    begin
                        s1_start = 1'b1;
                        if (view.cart < ROM_BASE)
                        begin
                            upd.status_set = 2'b01;
                            if (in_save)
                            begin
                                s1_kind = flash_reg ? KIND_FLASH_RDRAM : KIND_SRAM_RDRAM;
                            end
                            else if (view.cart >= IGNORE_BASE && view.cart < SAVE_BASE)
                            begin
                                s1_kind = KIND_IGNORED;
                            end
                            else
                            begin
                                s1_kind = KIND_ERROR;
                            end
                        end
                        else if (view.cart >= BOOT_BASE)
                        begin
                            upd.status_set = 2'b01;
                            s1_kind        = KIND_IGNORED;
                        end
                        else
                        begin
                            upd.status_set = 2'b11;
                            s1_rom         = 1'b1;
                        end
                    end
                    RG_STATUS:
                    begin
                        s1_clr = s1_value_reg[1] & s1_mask_reg[1];
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_DONE:
            begin
                upd.status_clr = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en_s1)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && req_valid)
        begin
            s1_op_reg    <= opcode;
            s1_idx_reg   <= reg_index;
            s1_value_reg <= write_value;
            s1_mask_reg  <= write_mask;
        end
    end

    // rdram bound clip
    assign dram_gt   = {1'b0, view.dram} > RDRAM_LIMIT;
    assign lim_minus = RDRAM_LIMIT - {1'b0, view.dram};

    always_comb
    begin
        if (dram_gt)
        begin
            len2 = 25'd0;
        end
        else if ({8'd0, len1} > lim_minus)
        begin
            len2 = lim_minus[24:0];
        end
        else
        begin
            len2 = len1;
        end
    end

    assign rom_err = off_gt || dram_gt;

    always_comb
    begin
        if (s1_rom)
        begin
            kind_next   = rom_err ? KIND_ERROR : KIND_ROM_RDRAM;
            length_next = rom_err ? 25'd0 : len2;
            delay_next  = len2[24:3];
        end
        else
        begin
            kind_next   = s1_kind;
            length_next = 25'd0;
            delay_next  = s1_start ? FIXED_DELAY : 22'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s1_valid_reg)
        begin
            rdata_reg     <= s1_rdata;
            kind_reg      <= kind_next;
            length_reg    <= length_next;
            offset_reg    <= s1_rom ? off : 26'd0;
            dram_addr_reg <= s1_start ? view.dram[22:0] : 23'd0;
            delay_reg     <= delay_next;
            clr_reg       <= s1_clr;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign read_data       = rdata_reg;
    assign dma_kind        = kind_reg;
    assign dma_length      = length_reg;
    assign rom_offset      = offset_reg;
    assign dram_address    = dram_addr_reg;
    assign interrupt_delay = delay_reg;
    assign interrupt_clear = clr_reg;

    // checks
    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && dma_kind == KIND_NONE |-> dram_address == 23'd0 && interrupt_delay == 22'd0)
        else $error("idle result carries transfer fields");

    a_len_rom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && dma_length != 25'd0 |-> dma_kind == KIND_ROM_RDRAM)
        else $error("length on a non rom transfer");

    a_clr_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && interrupt_clear |-> dma_kind == KIND_NONE && read_data == 32'd0)
        else $error("interrupt clear with other activity");

    a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("stall with an empty result stage");

endmodule

`default_nettype wire

// ----- sv/cdrc_regs.sv -----
// controller register file with masked merges and status bit updates
`default_nettype none

module cdrc_regs
    import cdrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cdrc_upd_t  upd,
    output cdrc_view_t      view
);

    logic [31:0] dram_reg;
    logic [31:0] cart_reg;
    logic [31:0] rdlen_reg;
    logic [31:0] wrlen_reg;
    logic [1:0]  status_reg;
    logic [7:0]  timing_reg [TIMING_COUNT];

    logic        is_write;
    logic [31:0] wrlen_next;
    logic [2:0]  tidx;

    assign is_write = (upd.op == OP_WRITE);
    assign tidx     = 3'(upd.idx - RG_TIMING_FIRST);

    always_comb
    begin
        wrlen_next = wrlen_reg;
        if (is_write && upd.idx == RG_WRLEN)
        begin
            wrlen_next = (wrlen_reg & ~upd.mask) | (upd.value & upd.mask);
        end
    end

    always_comb
    begin
        view.dram  = dram_reg;
        view.cart  = cart_reg;
        view.wrlen = wrlen_next;
        unique case (upd.idx) inside
            RG_DRAM:   view.rd_word = dram_reg;
            RG_CART:   view.rd_word = cart_reg;
            RG_RDLEN:  view.rd_word = rdlen_reg;
            RG_WRLEN:  view.rd_word = wrlen_reg;
            RG_STATUS: view.rd_word = {30'd0, status_reg};
            [RG_TIMING_FIRST:RG_TIMING_LAST]:
                view.rd_word = {24'd0, timing_reg[tidx]};
            default:   view.rd_word = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dram_reg   <= 32'd0;
            cart_reg   <= 32'd0;
            rdlen_reg  <= 32'd0;
            wrlen_reg  <= 32'd0;
            status_reg <= 2'd0;
            for (int k = 0; k < TIMING_COUNT; k++)
            begin
                timing_reg[k] <= 8'd0;
            end
        end
        else if (upd.en)
        begin
            wrlen_reg  <= wrlen_next;
            status_reg <= (status_reg & ~{2{upd.status_clr}}) | upd.status_set;
            if (is_write && upd.idx == RG_DRAM)
            begin
                dram_reg <= (dram_reg & ~upd.mask) | (upd.value & upd.mask);
            end
            if (is_write && upd.idx == RG_CART)
            begin
                cart_reg <= (cart_reg & ~upd.mask) | (upd.value & upd.mask);
            end
            if (is_write && upd.idx == RG_RDLEN)
            begin
                rdlen_reg <= (rdlen_reg & ~upd.mask) | (upd.value & upd.mask);
            end
            for (int k = 0; k < TIMING_COUNT; k++)
            begin
                if (is_write && upd.idx == RG_TIMING_FIRST + 4'(k))
                begin
                    timing_reg[k] <= (timing_reg[k] & ~upd.mask[7:0])
                                   | (upd.value[7:0] & upd.mask[7:0]);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- bench/cart_dma_register_controller_tb.sv -----
// self-checking bench for the cartridge dma register controller
`timescale 1ns / 100ps

module cart_dma_register_controller_tb
    import cdrc_pkg::*;
;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         REG_WORDS   = 13;
    localparam int         PHASE_ITEMS = 80;
    localparam int         HOLD_CYCLES = 80;
    localparam int         DRAIN_WAIT  = 6;
    localparam int         TIMEOUT_NS  = 2000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] mask;
    } access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  kind;
        logic [24:0] length;
        logic [25:0] offset;
        logic [22:0] dram;
        logic [21:0] delay;
        logic        clear;
    } descriptor_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  opcode = '0;
    logic [3:0]  reg_index = '0;
    logic [31:0] write_value = '0;
    logic [31:0] write_mask = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] read_data;
    logic [2:0]  dma_kind;
    logic [24:0] dma_length;
    logic [25:0] rom_offset;
    logic [22:0] dram_address;
    logic [21:0] interrupt_delay;
    logic        interrupt_clear;

    logic [31:0] reg_words [0:REG_WORDS-1];
    logic [26:0] rom_bytes_cfg;
    logic        save_flash;

    access_t     access_q[$];
    descriptor_t descriptor_q[$];
    access_t     offered;
    int          queued_cnt = 0;
    int          accepted_cnt = 0;
    int          checked_cnt = 0;
    int          transfer_cnt = 0;
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        pressure_on = 1'b0;
    logic        hold_used = 1'b0;
    int          hold_left = 0;

    cart_dma_register_controller u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .opcode          (opcode),
        .reg_index       (reg_index),
        .write_value     (write_value),
        .write_mask      (write_mask),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .read_data       (read_data),
        .dma_kind        (dma_kind),
        .dma_length      (dma_length),
        .rom_offset      (rom_offset),
        .dram_address    (dram_address),
        .interrupt_delay (interrupt_delay),
        .interrupt_clear (interrupt_clear)
    );

    function automatic logic in_save_window(input logic [31:0] cart);
        return cart >= SAVE_BASE && cart < SAVE_END;
    endfunction

    function automatic descriptor_t predict_descriptor(input access_t a);
        descriptor_t d;
        logic [31:0] cart;
        logic [31:0] diff;
        logic [31:0] wv;
        logic [31:0] wm;
        logic [63:0] dram64;
        logic [63:0] rom64;
        logic [63:0] len;
        logic [63:0] off;
        d = '0;
        case (a.op)
            OP_READ:
            begin
                if (a.idx < REG_WORDS)
                    d.read_data = reg_words[a.idx];
            end
            OP_WRITE:
            begin
                wv = a.value;
                wm = a.mask;
                if (a.idx >= RG_TIMING_FIRST && a.idx <= RG_TIMING_LAST)
                begin
                    wv = a.value & 32'hff;
                    wm = a.mask & 32'hff;
                end
                if (a.idx != RG_STATUS && a.idx < REG_WORDS)
                    reg_words[a.idx] = (reg_words[a.idx] & ~wm) | (wv & wm);
                cart = reg_words[RG_CART];
                dram64 = {32'd0, reg_words[RG_DRAM]};
                if (a.idx == RG_STATUS)
                    d.clear = a.value[1] & a.mask[1];
                else if (a.idx == RG_RDLEN)
                begin
                    d.kind = in_save_window(cart)
                        ? (save_flash ? KIND_RDRAM_FLASH : KIND_RDRAM_SRAM) : KIND_ERROR;
                    d.dram = reg_words[RG_DRAM][22:0];
                    d.delay = FIXED_DELAY;
                    reg_words[RG_STATUS] = reg_words[RG_STATUS] | 32'd1;
                end
                else if (a.idx == RG_WRLEN)
                begin
                    d.dram = reg_words[RG_DRAM][22:0];
                    if (cart < ROM_BASE || cart >= BOOT_BASE)
                    begin
                        if (cart >= BOOT_BASE)
                            d.kind = KIND_IGNORED;
                        else if (in_save_window(cart))
                            d.kind = save_flash ? KIND_FLASH_RDRAM : KIND_SRAM_RDRAM;
                        else if (cart >= IGNORE_BASE && cart < SAVE_BASE)
                            d.kind = KIND_IGNORED;
                        else
                            d.kind = KIND_ERROR;
                        d.delay = FIXED_DELAY;
                        reg_words[RG_STATUS] = reg_words[RG_STATUS] | 32'd1;
                    end
                    else
                    begin
                        len = {40'd0, reg_words[RG_WRLEN][23:0]} + 64'd1;
                        diff = cart - ROM_BASE;
                        off = {38'd0, diff[25:0]};
                        rom64 = {37'd0, rom_bytes_cfg};
                        if (off + len > rom64)
                            len = (off > rom64) ? 64'd0 : rom64 - off;
                        if (dram64 + len > RDRAM_LIMIT)
                            len = (dram64 > RDRAM_LIMIT) ? 64'd0 : RDRAM_LIMIT - dram64;
                        d.offset = off[25:0];
                        d.delay = len[24:3];
                        reg_words[RG_STATUS] = reg_words[RG_STATUS] | 32'd3;
                        if (off > rom64 || dram64 > RDRAM_LIMIT)
                            d.kind = KIND_ERROR;
                        else
                        begin
                            d.kind = KIND_ROM_RDRAM;
                            d.length = len[24:0];
                        end
                    end
                end
            end
            OP_DONE:
                reg_words[RG_STATUS] = reg_words[RG_STATUS] & ~32'd3;
            default:
                d = '0;
        endcase
        if (d.kind != KIND_NONE)
            transfer_cnt++;
        return d;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic queue_access(input logic [1:0] op, input logic [3:0] idx,
                                input logic [31:0] value, input logic [31:0] mask);
        access_t a;
        a.op = op;
        a.idx = idx;
        a.value = value;
        a.mask = mask;
        access_q.push_back(a);
        queued_cnt++;
    endtask

    function automatic logic [31:0] pick_mask();
        return ($urandom_range(99, 0) < 80) ? 32'hFFFF_FFFF : $urandom;
    endfunction

    function automatic logic [31:0] pick_cart();
        case ($urandom_range(5, 0))
            0: return SAVE_BASE + $urandom_range(32'h0000_FFFF, 0);
            1: return IGNORE_BASE + $urandom_range(32'h01FF_FFFF, 0);
            2: return ROM_BASE + $urandom_range(32'h00FF_FFFF, 0);
            3: return ROM_BASE + $urandom_range(32'h0FBF_FFFF, 0);
            4: return BOOT_BASE + $urandom_range(32'hE03F_FFFF, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dram();
        case ($urandom_range(3, 0))
            0, 1: return $urandom_range(32'h007F_FFFF, 0);
            2: return 32'h007F_FFFF - $urandom_range(255, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(3, 0))
            0, 1: return $urandom_range(32'h0000_3FFF, 0);
            2: return 32'h00FF_FFFF - $urandom_range(32'h0000_FFFF, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_transfer();
        logic [3:0] peek;
        queue_access(OP_WRITE, RG_DRAM, pick_dram(), pick_mask());
        queue_access(OP_WRITE, RG_CART, pick_cart(), pick_mask());
        if ($urandom_range(99, 0) < 60)
            queue_access(OP_WRITE, RG_WRLEN, pick_length(), pick_mask());
        else
            queue_access(OP_WRITE, RG_RDLEN, $urandom, pick_mask());
        if ($urandom_range(2, 0) == 0)
        begin
            peek = 4'($urandom_range(15, 0));
            queue_access(OP_READ, peek, $urandom, $urandom);
        end
        if ($urandom_range(2, 0) == 0)
            queue_access(OP_DONE, 4'($urandom_range(15, 0)), $urandom, $urandom);
        if ($urandom_range(3, 0) == 0)
            queue_access(OP_WRITE, RG_STATUS, $urandom | 32'd2, pick_mask());
    endtask

    task automatic queue_noise();
        logic [3:0] idx;
        idx = 4'($urandom_range(15, 0));
        if ($urandom_range(1, 0) == 0)
            queue_access(2'($urandom_range(3, 0)), idx, $urandom, $urandom);
        else
        begin
            queue_access(OP_WRITE, idx, $urandom, pick_mask());
            queue_access(OP_READ, idx, $urandom, $urandom);
        end
    endtask

    task automatic fill_random(input int count);
        int target;
        target = queued_cnt + count;
        while (queued_cnt < target)
        begin
            if ($urandom_range(99, 0) < 75)
                queue_transfer();
            else
                queue_noise();
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || descriptor_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_setting(input logic [1:0] index, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_ROM_BYTES)
            rom_bytes_cfg = data[26:0];
        else if (index == CFG_SAVE_IS_FLASH)
            save_flash = data[0];
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
            begin
                descriptor_q.push_back(predict_descriptor(offered));
                accepted_cnt++;
            end
            if (!req_valid || !req_stall)
            begin
                if (access_q.size() != 0
                    && (hold_left != 0 || $urandom_range(99, 0) >= tx_idle_pct))
                begin
                    offered = access_q.pop_front();
                    req_valid <= 1'b1;
                    opcode <= offered.op;
                    reg_index <= offered.idx;
                    write_value <= offered.value;
                    write_mask <= offered.mask;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_on && !hold_used)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_used <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end

    // result beats
    always @(posedge clk)
    begin
        descriptor_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (descriptor_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing outstanding", $time);
            end
            else
            begin
                want = descriptor_q.pop_front();
                checked_cnt++;
                check_field("read_data", want.read_data, read_data);
                check_field("dma_kind", 32'(want.kind), 32'(dma_kind));
                check_field("dma_length", 32'(want.length), 32'(dma_length));
                check_field("rom_offset", 32'(want.offset), 32'(rom_offset));
                check_field("dram_address", 32'(want.dram), 32'(dram_address));
                check_field("interrupt_delay", 32'(want.delay), 32'(interrupt_delay));
                check_field("interrupt_clear", 32'(want.clear), 32'(interrupt_clear));
            end
        end
    end

    initial
    begin
        int ph;
        for (int i = 0; i < REG_WORDS; i++)
            reg_words[i] = '0;
        rom_bytes_cfg = ROM_BYTES_RESET;
        save_flash = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 12;
        rx_idle_pct <= 48;

        queue_access(OP_READ, RG_DRAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_DRAM, 32'h0012_3450, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, SAVE_BASE, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_RDLEN, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_access(OP_READ, RG_STATUS, 32'h0, 32'h0);
        queue_access(OP_WRITE, RG_STATUS, 32'h0000_0002, 32'h0000_0002);
        queue_access(OP_WRITE, RG_STATUS, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
        queue_access(OP_DONE, RG_STATUS, 32'h0, 32'h0);
        queue_access(OP_WRITE, RG_CART, IGNORE_BASE, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'h0000_0010, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'h0000_0010, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_RDLEN, 32'h0000_0010, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, BOOT_BASE, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'h0000_0010, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, ROM_BASE, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, 32'h1FBF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'h0000_0100, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_DRAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_CART, ROM_BASE + 32'd8, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_WRLEN, 32'h0000_0100, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_TIMING_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, RG_TIMING_LAST, 32'h0000_005A, 32'hF0F0_F0F0);
        queue_access(OP_WRITE, 4'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_READ, 4'd15, 32'h0, 32'h0);
        queue_access(OP_UNUSED, RG_CART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_setting(CFG_ROM_BYTES, 32'd0);
                    write_setting(CFG_SAVE_IS_FLASH, 32'd1);
                end
                1:
                begin
                    write_setting(CFG_ROM_BYTES, 32'd67108864);
                    write_setting(CFG_SAVE_IS_FLASH, 32'd0);
                    tx_idle_pct <= 48;
                    rx_idle_pct <= 12;
                end
                2:
                begin
                    write_setting(CFG_ROM_BYTES, $urandom_range(67108864, 1));
                    write_setting(CFG_SAVE_IS_FLASH, 32'd1);
                    pressure_on <= 1'b1;
                end
                3:
                begin
                    write_setting(CFG_ROM_BYTES, {5'd0, ROM_BYTES_RESET});
                    write_setting(CFG_SAVE_IS_FLASH, 32'd0);
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
                default:
                begin
                    write_setting(CFG_ROM_BYTES, $urandom_range(32'h007F_FFFF, 0));
                    write_setting(CFG_SAVE_IS_FLASH, $urandom_range(1, 0));
                end
            endcase
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("covered %0d bus accesses, %0d results checked, %0d transfers started",
                 accepted_cnt, checked_cnt, transfer_cnt);
        $display("rom sizes from zero to 64 MiB, sram and flash saves, one long output hold-off");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
